// ----- design/stxrx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stxrx_pkg
// Shared types and constants for the serial port character queues.
// ----------------------------------------------------------------------------
package stxrx_pkg;

    // Depth of each ring; must be a power of two.
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Request types.
    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_READ     = 2'd1;
    localparam logic [1:0] REQ_TX_EMPTY = 2'd2;
    localparam logic [1:0] REQ_RX_FULL  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_RETRY = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_byte;
        logic       tx_reg_empty;
        logic [7:0] rx_byte;
        logic       rx_ready;
    } stxrx_req_t;

    typedef struct packed {
        logic       tx_valid;
        logic [8:0] tx_word;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [1:0] status;
        logic       wake;
    } stxrx_res_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic exec;
        logic push_cr;
        logic load_rd;
        logic finish;
    } stxrx_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic need_cr;
        logic need_rd;
    } stxrx_sts_t;

endpackage
`default_nettype wire

// ----- design/stxrx_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stxrx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stxrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/stxrx_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stxrx_ctrl
// Sequencer: capture, execute, optional carriage return push or read-out.
// ----------------------------------------------------------------------------
module stxrx_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire stxrx_pkg::stxrx_sts_t sts,
    output stxrx_pkg::stxrx_cmd_t     cmd
);
    import stxrx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_CR   = 4'b0100,
        S_RD   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.need_rd)
                begin
                    state_next = S_RD;
                end
                else if (sts.need_cr)
                begin
                    state_next = S_CR;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CR:
            begin
                cmd.push_cr = 1'b1;
                cmd.finish  = 1'b1;
                state_next  = S_IDLE;
            end
            S_RD:
            begin
                cmd.load_rd = 1'b1;
                cmd.finish  = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/stxrx_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stxrx_dp
// Datapath: send and receive rings, pointers, counts and result register.
// ----------------------------------------------------------------------------
module stxrx_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    input  wire stxrx_pkg::stxrx_req_t request,
    input  wire stxrx_pkg::stxrx_cmd_t cmd,
    output stxrx_pkg::stxrx_sts_t      sts,
    output stxrx_pkg::stxrx_res_t      result,
    output logic                       result_valid
);
    import stxrx_pkg::*;

    stxrx_req_t req_reg;
    stxrx_res_t result_reg, result_next;
    logic       done_reg;
    logic       nb_reg;

    logic [PTR_W-1:0] send_head_reg, send_head_next;
    logic [PTR_W-1:0] send_tail_reg, send_tail_next;
    logic [CNT_W-1:0] send_count_reg, send_count_next;
    logic [PTR_W-1:0] recv_head_reg, recv_head_next;
    logic [PTR_W-1:0] recv_tail_reg, recv_tail_next;
    logic [CNT_W-1:0] recv_count_reg, recv_count_next;

    logic       send_we, recv_we;
    logic [7:0] send_wdata;
    logic [7:0] send_rdata, recv_rdata;

    logic             direct, is_lf, retry;
    logic             send_full, send_empty, recv_full, recv_empty;
    logic [1:0]       need;
    logic [CNT_W-1:0] send_room;

    stxrx_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_send_ram (
        .clk   (clk),
        .we    (send_we),
        .waddr (send_tail_reg),
        .wdata (send_wdata),
        .raddr (send_head_reg),
        .rdata (send_rdata)
    );

    stxrx_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_recv_ram (
        .clk   (clk),
        .we    (recv_we),
        .waddr (recv_tail_reg),
        .wdata (req_reg.rx_byte),
        .raddr (recv_head_reg),
        .rdata (recv_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            nb_reg         <= 1'b0;
            send_head_reg  <= '0;
            send_tail_reg  <= '0;
            send_count_reg <= '0;
            recv_head_reg  <= '0;
            recv_tail_reg  <= '0;
            recv_count_reg <= '0;
        end
        else
        begin
            done_reg       <= cmd.finish;
            if (cfg_we)
            begin
                nb_reg <= cfg_wdata;
            end
            send_head_reg  <= send_head_next;
            send_tail_reg  <= send_tail_next;
            send_count_reg <= send_count_next;
            recv_head_reg  <= recv_head_next;
            recv_tail_reg  <= recv_tail_next;
            recv_count_reg <= recv_count_next;
        end
    end

    always_comb
    begin
        send_full  = send_count_reg == CNT_W'(QUEUE_DEPTH);
        send_empty = send_count_reg == '0;
        recv_full  = recv_count_reg == CNT_W'(QUEUE_DEPTH);
        recv_empty = recv_count_reg == '0;
        direct     = send_empty && req_reg.tx_reg_empty;
        is_lf      = req_reg.write_byte == CH_LF;
        // A queued newline takes two slots, a direct one only its carriage return.
        need       = {1'b0, ~direct} + {1'b0, is_lf};
        send_room  = CNT_W'(QUEUE_DEPTH) - send_count_reg;
        retry      = (CNT_W'(need) > send_room) && !nb_reg;

        sts.need_cr = (req_reg.req_type == REQ_WRITE) && !retry && is_lf;
        sts.need_rd = ((req_reg.req_type == REQ_READ) && !recv_empty) ||
                      ((req_reg.req_type == REQ_TX_EMPTY) && !send_empty);

        send_head_next  = send_head_reg;
        send_tail_next  = send_tail_reg;
        send_count_next = send_count_reg;
        recv_head_next  = recv_head_reg;
        recv_tail_next  = recv_tail_reg;
        recv_count_next = recv_count_reg;
        send_we         = 1'b0;
        send_wdata      = req_reg.write_byte;
        recv_we         = 1'b0;
        result_next     = result_reg;

        if (cmd.exec)
        begin
            result_next = '0;
            unique case (req_reg.req_type)
                REQ_WRITE:
                begin
                    if (retry)
                    begin
                        result_next.status = ST_RETRY;
                    end
                    else if (direct)
                    begin
                        result_next.tx_valid = 1'b1;
                        result_next.tx_word  = {1'b1, req_reg.write_byte};
                    end
                    else if (!send_full)
                    begin
                        send_we         = 1'b1;
                        send_tail_next  = send_tail_reg + PTR_W'(1);
                        send_count_next = send_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_next.status = ST_DROP;
                    end
                end
                REQ_READ:
                begin
                    if (!recv_empty)
                    begin
                        recv_head_next  = recv_head_reg + PTR_W'(1);
                        recv_count_next = recv_count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        result_next.status = ST_EMPTY;
                    end
                end
                REQ_TX_EMPTY:
                begin
                    if (!send_empty)
                    begin
                        send_head_next  = send_head_reg + PTR_W'(1);
                        send_count_next = send_count_reg - CNT_W'(1);
                    end
                end
                REQ_RX_FULL:
                begin
                    if (req_reg.rx_ready)
                    begin
                        if (!recv_full)
                        begin
                            recv_we         = 1'b1;
                            recv_tail_next  = recv_tail_reg + PTR_W'(1);
                            recv_count_next = recv_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            result_next.status = ST_DROP;
                        end
                        result_next.wake = !nb_reg;
                    end
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end

        if (cmd.push_cr)
        begin
            if (!send_full)
            begin
                send_we         = 1'b1;
                send_wdata      = CH_CR;
                send_tail_next  = send_tail_reg + PTR_W'(1);
                send_count_next = send_count_reg + CNT_W'(1);
            end
            else
            begin
                result_next.status = ST_DROP;
            end
        end

        // The ring read was issued at the old head during execute.
        if (cmd.load_rd)
        begin
            result_next = '0;
            if (req_reg.req_type == REQ_READ)
            begin
                result_next.read_valid = 1'b1;
                result_next.read_byte  = recv_rdata;
            end
            else
            begin
                result_next.tx_valid = 1'b1;
                result_next.tx_word  = {1'b1, send_rdata};
                result_next.wake     = !nb_reg;
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = done_reg;

endmodule
`default_nettype wire

// ----- design/serial_tx_rx_char_queues.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// serial_tx_rx_char_queues
// Send and receive byte rings for a serial port with newline expansion.
// ----------------------------------------------------------------------------
// Each transaction is captured at start, executes, and then raises the result
// strobe from a register; a queue pop or any newline write that is not refused
// first passes an extra read-out or carriage return state (registered ring read,
// or the carriage return push through the single ring write port); busy is high meanwhile.
// Reset: rst_n clears pointers, counts, mode and strobe; ring contents are not
// cleared. The receiver cannot stall the result strobe.
module serial_tx_rx_char_queues (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire stxrx_pkg::stxrx_req_t request,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    output stxrx_pkg::stxrx_res_t      result,
    output logic                       result_valid
);
    import stxrx_pkg::*;

    stxrx_cmd_t cmd;
    stxrx_sts_t sts;

    stxrx_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    stxrx_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .request      (request),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
`default_nettype wire
